// ----- src/backpressure_queue_scheduler_assert.svh -----
// Assertion macros shared by the scheduler modules.
`ifndef BACKPRESSURE_QUEUE_SCHEDULER_ASSERT_SVH
`define BACKPRESSURE_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BQS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BQS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/bqs_pkg.sv -----
// Shared types and constants of the backpressure queue scheduler.
package bqs_pkg;

  localparam int SLOTS          = 16;
  localparam int SLOT_W         = $clog2(SLOTS);
  localparam int QUEUE_CAP_INT  = 1024;
  localparam int LEN_W          = $clog2(QUEUE_CAP_INT + 1);
  localparam int DROP_W         = 16;
  localparam int WEIGHT_W       = 16;
  localparam int BACKLOG_W      = 20;
  localparam int RATE_W         = 7;
  localparam int SCORE_W        = 35;
  localparam int DIFF_W         = WEIGHT_W + LEN_W + 1;
  localparam int ACTION_W       = 2;
  localparam int MODE_W         = 2;
  localparam int THR_W          = 20;
  localparam int MAXD_W         = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 20;
  localparam int LFSR_W         = 16;

  localparam logic [LEN_W-1:0]          QUEUE_CAPACITY = LEN_W'(QUEUE_CAP_INT);
  localparam logic [SLOT_W-1:0]         SLOT_LAST      = SLOT_W'(SLOTS - 1);
  localparam logic [DROP_W-1:0]         DROP_MAX       = '1;
  localparam logic signed [SCORE_W-1:0] SCORE_NONE     = '1;
  localparam logic [LFSR_W-1:0]         LFSR_SEED      = 16'hACE1;
  localparam logic [LFSR_W-1:0]         LFSR_TAPS      = 16'hB400;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DROPS      = 2'd2;

  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_ARRIVE = 2'd1,
    ACT_DEPART = 2'd2,
    ACT_SET    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TICK_END,
    ST_UPDATE
  } state_t;

  // One slot presented to the score unit.
  typedef struct packed {
    logic                 clear;
    logic                 valid;
    logic [SLOT_W-1:0]    idx;
    logic [WEIGHT_W-1:0]  weight;
    logic [LEN_W-1:0]     len;
    logic [BACKLOG_W-1:0] backlog;
    logic [RATE_W-1:0]    rate;
  } score_feed_t;

  // Running pick of the score unit.
  typedef struct packed {
    logic                      pending;
    logic                      chosen_valid;
    logic [SLOT_W-1:0]         chosen;
    logic signed [SCORE_W-1:0] best;
  } score_stat_t;

endpackage

// ----- src/bqs_item_if.sv -----
// Input channel of the scheduler: one word per item.
interface bqs_item_if;
  logic                           valid;
  logic                           ready;
  logic [bqs_pkg::ACTION_W-1:0]   action;
  logic [bqs_pkg::SLOT_W-1:0]     slot;
  logic [bqs_pkg::WEIGHT_W-1:0]   slot_weight;
  logic [bqs_pkg::BACKLOG_W-1:0]  neighbor_backlog;
  logic [bqs_pkg::RATE_W-1:0]     link_rate;

  modport source (output valid, action, slot, slot_weight, neighbor_backlog, link_rate,
                  input ready);
  modport sink   (input valid, action, slot, slot_weight, neighbor_backlog, link_rate,
                  output ready);
endinterface

// ----- src/bqs_result_if.sv -----
// Result channel of the scheduler: one word per item.
interface bqs_result_if;
  logic                             valid;
  logic                             ready;
  logic [bqs_pkg::SLOT_W-1:0]       chosen_slot;
  logic                             chosen_valid;
  logic                             pull_ready;
  logic signed [bqs_pkg::SCORE_W-1:0] best_score;
  logic                             accepted;
  logic [bqs_pkg::LEN_W-1:0]        slot_length;

  modport source (output valid, chosen_slot, chosen_valid, pull_ready, best_score, accepted,
                  slot_length, input ready);
  modport sink   (input valid, chosen_slot, chosen_valid, pull_ready, best_score, accepted,
                  slot_length, output ready);
endinterface

// ----- src/backpressure_queue_scheduler.sv -----
// Top level of the max-weight backpressure queue scheduler.
// Keeps sixteen queue slots (in-use flag, length, virtual drops, weight, neighbor
// backlog, head link rate) in flip-flop tables with one read/write address per
// cycle. Every input word gives exactly one result word. Arrival, departure and
// set words pass through the update state after acceptance, and a new word is
// taken only once the sequencer is back in idle. A tick in plain mode goes
// straight to the tick-end state and picks the lowest in-use slot.
// A tick in the other modes sweeps the slots in index order, one slot per cycle,
// through a three-stage multiply-compare pipeline ((weight*length - backlog)*rate
// and a running max with an LFSR tie break); the virtual-drop update of each slot
// is written back in the same cycle it is read. After the last slot the sequencer
// waits in the tick-end state until the pipeline has drained and the output
// register is free, then registers the result. The input is ready only when the
// sequencer is idle; the result sits in an output register, so the next word is
// taken while an earlier result still waits, and only the final step of an item
// stalls on it.
// Configuration writes (policy_mode, drop_threshold, max_drops_per_tick) are
// expected while the block is idle.
`include "backpressure_queue_scheduler_assert.svh"

module backpressure_queue_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bqs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bqs_pkg::CFG_DATA_W-1:0]    cfg_data,
  bqs_item_if.sink                          item,
  bqs_result_if.source                      result
);

  // config registers
  logic [bqs_pkg::MODE_W-1:0]  policy_mode;
  logic [bqs_pkg::THR_W-1:0]   drop_threshold;
  logic [bqs_pkg::MAXD_W-1:0]  max_drops_per_tick;

  // slot tables
  logic [bqs_pkg::SLOTS-1:0]     slot_in_use;
  logic [bqs_pkg::LEN_W-1:0]     queue_length  [bqs_pkg::SLOTS];
  logic [bqs_pkg::DROP_W-1:0]    virtual_drops [bqs_pkg::SLOTS];
  logic [bqs_pkg::WEIGHT_W-1:0]  weight_table  [bqs_pkg::SLOTS];
  logic [bqs_pkg::BACKLOG_W-1:0] backlog_table [bqs_pkg::SLOTS];
  logic [bqs_pkg::RATE_W-1:0]    rate_table    [bqs_pkg::SLOTS];

  // sequencer and latched word
  bqs_pkg::state_t               state;
  bqs_pkg::state_t               state_next;
  logic [bqs_pkg::SLOT_W-1:0]    idx;
  bqs_pkg::action_t              act;
  logic [bqs_pkg::SLOT_W-1:0]    slot_q;
  logic [bqs_pkg::WEIGHT_W-1:0]  weight_q;
  logic [bqs_pkg::BACKLOG_W-1:0] backlog_q;
  logic [bqs_pkg::RATE_W-1:0]    rate_q;

  // result register
  logic                              res_valid;
  logic [bqs_pkg::SLOT_W-1:0]        res_chosen;
  logic                              res_cv;
  logic                              res_pull;
  logic signed [bqs_pkg::SCORE_W-1:0] res_best;
  logic                              res_acc;
  logic [bqs_pkg::LEN_W-1:0]         res_len;
  logic [bqs_pkg::SLOT_W-1:0]        res_chosen_next;
  logic                              res_cv_next;
  logic                              res_pull_next;
  logic signed [bqs_pkg::SCORE_W-1:0] res_best_next;
  logic                              res_acc_next;
  logic [bqs_pkg::LEN_W-1:0]         res_len_next;

  // datapath
  logic                          accept;
  logic                          plain;
  logic                          out_free;
  logic                          tick_done;
  logic                          upd_done;
  logic                          load;
  logic [bqs_pkg::SLOT_W-1:0]    first_idx;
  logic                          first_valid;
  logic [bqs_pkg::SLOT_W-1:0]    pick_idx;
  logic [bqs_pkg::SLOT_W-1:0]    rd_idx;
  logic                          rd_in_use;
  logic [bqs_pkg::LEN_W-1:0]     rd_len;
  logic [bqs_pkg::DROP_W-1:0]    rd_drops;
  logic [bqs_pkg::LEN_W-1:0]     add_amt;
  logic [bqs_pkg::DROP_W-1:0]    rem_amt;
  logic [bqs_pkg::DROP_W-1:0]    maxd_ext;
  logic [bqs_pkg::DROP_W:0]      drop_sum;
  logic                          arrive_ok;
  logic                          depart_ok;
  logic                          ql_we;
  logic [bqs_pkg::LEN_W-1:0]     ql_wdata;
  logic                          vd_we;
  logic [bqs_pkg::DROP_W-1:0]    vd_wdata;
  logic                          set_we;
  logic                          tick_cv;

  bqs_pkg::score_feed_t          su_feed;
  bqs_pkg::score_stat_t          su_stat;

  bqs_score_unit u_score (
    .clk  (clk),
    .rst  (rst),
    .feed (su_feed),
    .stat (su_stat)
  );

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode        <= bqs_pkg::MODE_W'(1);
      drop_threshold     <= '0;
      max_drops_per_tick <= bqs_pkg::MAXD_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        bqs_pkg::REG_POLICY_MODE:    policy_mode        <= cfg_data[bqs_pkg::MODE_W-1:0];
        bqs_pkg::REG_DROP_THRESHOLD: drop_threshold     <= cfg_data[bqs_pkg::THR_W-1:0];
        bqs_pkg::REG_MAX_DROPS:      max_drops_per_tick <= cfg_data[bqs_pkg::MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- shared read port ----------------
  assign plain = policy_mode == bqs_pkg::MODE_PLAIN;

  // lowest in-use slot for plain mode
  always_comb begin
    first_idx = '0;
    for (int i = bqs_pkg::SLOTS - 1; i >= 0; i--) begin
      if (slot_in_use[i]) begin
        first_idx = bqs_pkg::SLOT_W'(i);
      end
    end
    first_valid = |slot_in_use;
  end

  assign pick_idx = plain ? first_idx : su_stat.chosen;
  assign tick_cv  = plain ? first_valid : su_stat.chosen_valid;

  always_comb begin
    case (state)
      bqs_pkg::ST_SCAN:     rd_idx = idx;
      bqs_pkg::ST_TICK_END: rd_idx = pick_idx;
      bqs_pkg::ST_UPDATE:   rd_idx = slot_q;
      default:              rd_idx = idx;
    endcase
  end

  assign rd_in_use = slot_in_use[rd_idx];
  assign rd_len    = queue_length[rd_idx];
  assign rd_drops  = virtual_drops[rd_idx];

  // virtual-drop rule for the slot being swept
  always_comb begin
    maxd_ext = bqs_pkg::DROP_W'(max_drops_per_tick);
    add_amt  = '0;
    if (bqs_pkg::DROP_W'(rd_len) > rd_drops) begin
      add_amt = (rd_len < max_drops_per_tick) ? rd_len : max_drops_per_tick;
    end
    rem_amt = '0;
    if (bqs_pkg::THR_W'(rd_drops) > drop_threshold) begin
      rem_amt = (rd_drops < maxd_ext) ? rd_drops : maxd_ext;
    end
    drop_sum = {1'b0, rd_drops} + (bqs_pkg::DROP_W+1)'(add_amt)
             - (bqs_pkg::DROP_W+1)'(rem_amt);
  end

  assign arrive_ok = rd_in_use && (rd_len < bqs_pkg::QUEUE_CAPACITY);
  assign depart_ok = rd_in_use && (rd_len != '0);

  // ---------------- sequencer ----------------
  assign accept    = item.valid && item.ready;
  assign out_free  = !res_valid || result.ready;
  assign tick_done = (state == bqs_pkg::ST_TICK_END) && !su_stat.pending && out_free;
  assign upd_done  = (state == bqs_pkg::ST_UPDATE) && out_free;
  assign load      = tick_done || upd_done;

  always_comb begin
    state_next = state;
    case (state)
      bqs_pkg::ST_IDLE: begin
        if (item.valid) begin
          if (item.action == bqs_pkg::ACT_TICK) begin
            state_next = plain ? bqs_pkg::ST_TICK_END : bqs_pkg::ST_SCAN;
          end else begin
            state_next = bqs_pkg::ST_UPDATE;
          end
        end
      end
      bqs_pkg::ST_SCAN: begin
        if (idx == bqs_pkg::SLOT_LAST) begin
          state_next = bqs_pkg::ST_TICK_END;
        end
      end
      bqs_pkg::ST_TICK_END: begin
        if (tick_done) begin
          state_next = bqs_pkg::ST_IDLE;
        end
      end
      bqs_pkg::ST_UPDATE: begin
        if (upd_done) begin
          state_next = bqs_pkg::ST_IDLE;
        end
      end
      default: state_next = bqs_pkg::ST_IDLE;
    endcase
  end

  // control and result values per state
  always_comb begin
    item.ready      = 1'b0;
    su_feed.clear   = 1'b0;
    su_feed.valid   = 1'b0;
    su_feed.idx     = rd_idx;
    su_feed.weight  = weight_table[rd_idx];
    su_feed.len     = rd_len;
    su_feed.backlog = backlog_table[rd_idx];
    su_feed.rate    = rate_table[rd_idx];
    ql_we           = 1'b0;
    ql_wdata        = rd_len;
    vd_we           = 1'b0;
    vd_wdata        = drop_sum[bqs_pkg::DROP_W] ? bqs_pkg::DROP_MAX
                                                : drop_sum[bqs_pkg::DROP_W-1:0];
    set_we          = 1'b0;
    res_chosen_next = '0;
    res_cv_next     = 1'b0;
    res_pull_next   = 1'b0;
    res_best_next   = bqs_pkg::SCORE_NONE;
    res_acc_next    = 1'b0;
    res_len_next    = rd_len;
    case (state)
      bqs_pkg::ST_IDLE: begin
        item.ready    = 1'b1;
        su_feed.clear = item.valid && (item.action == bqs_pkg::ACT_TICK);
      end
      bqs_pkg::ST_SCAN: begin
        // score and drop-update the same slot; score uses the pre-drop length
        su_feed.valid = rd_in_use;
        ql_we         = rd_in_use;
        ql_wdata      = rd_len - add_amt;
        vd_we         = rd_in_use;
      end
      bqs_pkg::ST_TICK_END: begin
        res_cv_next     = tick_cv;
        res_chosen_next = tick_cv ? pick_idx : '0;
        res_len_next    = tick_cv ? rd_len : '0;
        res_pull_next   = tick_cv && (rd_len != '0);
        res_best_next   = plain ? bqs_pkg::SCORE_NONE : su_stat.best;
      end
      bqs_pkg::ST_UPDATE: begin
        case (act)
          bqs_pkg::ACT_SET: begin
            set_we       = upd_done;
            res_acc_next = 1'b1;
          end
          bqs_pkg::ACT_ARRIVE: begin
            ql_we        = upd_done && arrive_ok;
            ql_wdata     = rd_len + bqs_pkg::LEN_W'(1);
            res_acc_next = arrive_ok;
            res_len_next = arrive_ok ? ql_wdata : rd_len;
          end
          bqs_pkg::ACT_DEPART: begin
            ql_we        = upd_done && depart_ok;
            ql_wdata     = rd_len - bqs_pkg::LEN_W'(1);
            res_acc_next = depart_ok;
            res_len_next = depart_ok ? ql_wdata : rd_len;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bqs_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        idx <= '0;
      end else if (state == bqs_pkg::ST_SCAN) begin
        idx <= idx + bqs_pkg::SLOT_W'(1);
      end
    end
  end

  // latched input word
  always_ff @(posedge clk) begin
    if (accept) begin
      act       <= bqs_pkg::action_t'(item.action);
      slot_q    <= item.slot;
      weight_q  <= item.slot_weight;
      backlog_q <= item.neighbor_backlog;
      rate_q    <= item.link_rate;
    end
  end

  // ---------------- slot tables ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_in_use <= '0;
      for (int i = 0; i < bqs_pkg::SLOTS; i++) begin
        queue_length[i]  <= '0;
        virtual_drops[i] <= '0;
        rate_table[i]    <= '0;
      end
    end else begin
      if (ql_we) begin
        queue_length[rd_idx] <= ql_wdata;
      end
      if (vd_we) begin
        virtual_drops[rd_idx] <= vd_wdata;
      end
      if (set_we) begin
        slot_in_use[rd_idx] <= 1'b1;
        rate_table[rd_idx]  <= rate_q;
      end
    end
  end

  // weight and backlog hold garbage until a set writes them
  always_ff @(posedge clk) begin
    if (set_we) begin
      weight_table[rd_idx]  <= weight_q;
      backlog_table[rd_idx] <= backlog_q;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_chosen <= res_chosen_next;
      res_cv     <= res_cv_next;
      res_pull   <= res_pull_next;
      res_best   <= res_best_next;
      res_acc    <= res_acc_next;
      res_len    <= res_len_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.chosen_slot  = res_chosen;
  assign result.chosen_valid = res_cv;
  assign result.pull_ready   = res_pull;
  assign result.best_score   = res_best;
  assign result.accepted     = res_acc;
  assign result.slot_length  = res_len;

  `BQS_ASSERT_NXT(a_scan_end, (state == bqs_pkg::ST_SCAN) && (idx == bqs_pkg::SLOT_LAST), state == bqs_pkg::ST_TICK_END, "sweep overran the last slot")
  `BQS_ASSERT_IMP(a_ready_drained, item.ready, !su_stat.pending, "word taken with scores in flight")
  `BQS_ASSERT_IMP(a_pick_in_use, tick_done && res_cv_next, slot_in_use[res_chosen_next], "picked a slot not in use")
  `BQS_ASSERT_IMP(a_len_cap, ql_we, ql_wdata <= bqs_pkg::QUEUE_CAPACITY, "queue length past capacity")

endmodule

// ----- src/bqs_score_unit.sv -----
// Score pipeline: (weight*len - backlog)*rate, then max pick with LFSR tie break.
`include "backpressure_queue_scheduler_assert.svh"

module bqs_score_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  bqs_pkg::score_feed_t  feed,
  output bqs_pkg::score_stat_t  stat
);

  logic                                    s1_valid;
  logic [bqs_pkg::SLOT_W-1:0]              s1_idx;
  logic signed [bqs_pkg::DIFF_W-1:0]       s1_diff;
  logic [bqs_pkg::RATE_W-1:0]              s1_rate;
  logic                                    s2_valid;
  logic [bqs_pkg::SLOT_W-1:0]              s2_idx;
  logic signed [bqs_pkg::SCORE_W-1:0]      s2_score;
  logic signed [bqs_pkg::SCORE_W-1:0]      best;
  logic [bqs_pkg::SLOT_W-1:0]              chosen;
  logic                                    chosen_valid;
  logic [bqs_pkg::LFSR_W-1:0]              lfsr;

  logic [bqs_pkg::WEIGHT_W+bqs_pkg::LEN_W-1:0]  wl;
  logic signed [bqs_pkg::DIFF_W-1:0]            diff;
  logic [bqs_pkg::RATE_W-1:0]                   rate_eff;
  logic signed [bqs_pkg::DIFF_W+bqs_pkg::RATE_W:0] prod;
  logic                                         gt;
  logic                                         eq;
  logic                                         take;
  logic                                         lfsr_step;
  logic [bqs_pkg::LFSR_W-1:0]                   lfsr_next;

  // stage 1: weight*length minus backlog; empty slot or zero rate scores at rate 1
  always_comb begin
    wl       = feed.weight * feed.len;
    diff     = signed'({1'b0, wl})
             - signed'({{(bqs_pkg::DIFF_W - bqs_pkg::BACKLOG_W){1'b0}}, feed.backlog});
    rate_eff = (feed.len == '0 || feed.rate == '0) ? bqs_pkg::RATE_W'(1) : feed.rate;
  end

  // stage 2: times rate
  assign prod = s1_diff * signed'({1'b0, s1_rate});

  // stage 3: compare; LFSR steps only on an exact tie
  always_comb begin
    gt        = s2_score > best;
    eq        = s2_score == best;
    lfsr_step = s2_valid && !gt && eq;
    take      = s2_valid && (gt || (eq && lfsr[0]));
    lfsr_next = {1'b0, lfsr[bqs_pkg::LFSR_W-1:1]} ^ (lfsr[0] ? bqs_pkg::LFSR_TAPS : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= feed.valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx   <= feed.idx;
    s1_diff  <= diff;
    s1_rate  <= rate_eff;
    s2_idx   <= s1_idx;
    s2_score <= prod[bqs_pkg::SCORE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best         <= bqs_pkg::SCORE_NONE;
      chosen       <= '0;
      chosen_valid <= 1'b0;
      lfsr         <= bqs_pkg::LFSR_SEED;
    end else begin
      if (lfsr_step) begin
        lfsr <= lfsr_next;
      end
      if (feed.clear) begin
        best         <= bqs_pkg::SCORE_NONE;
        chosen       <= '0;
        chosen_valid <= 1'b0;
      end else if (take) begin
        best         <= s2_score;
        chosen       <= s2_idx;
        chosen_valid <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.pending      = s1_valid || s2_valid;
    stat.chosen_valid = chosen_valid;
    stat.chosen       = chosen;
    stat.best         = best;
  end

  `BQS_ASSERT_IMP(a_clear_empty, feed.clear, !(s1_valid || s2_valid), "pick cleared mid scan")
  `BQS_ASSERT_IMP(a_best_floor, chosen_valid, best >= bqs_pkg::SCORE_NONE, "pick below floor")
  `BQS_ASSERT_IMP(a_lfsr_live, 1'b1, lfsr != '0, "tie LFSR locked at zero")

endmodule
